/* sv/ffrc_pkg.sv */
// Package for the flag-framed byte receiver with CRC-16 check.
// Holds the result word type, config struct, status and register codes, CRC step.
// No dependencies.
`default_nettype none

package ffrc_pkg;

  // Compile-time payload cap; the 6-bit limit register is clamped to it.
  localparam int unsigned MAX_PAYLOAD = 32;
  localparam logic [5:0] LIMIT_CAP = (MAX_PAYLOAD > 63) ? 6'd63 : 6'(MAX_PAYLOAD);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_START_FLAG = 2'd0;
  localparam logic [1:0] REG_END_FLAG   = 2'd1;
  localparam logic [1:0] REG_LIMIT      = 2'd2;

  localparam logic [7:0] START_FLAG_RST = 8'h7E;
  localparam logic [7:0] END_FLAG_RST   = 8'h7D;
  localparam logic [5:0] LIMIT_RST      = 6'd32;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_CRC_BAD = 2'd1,
    STAT_END_BAD = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] start_flag;
    logic [7:0] end_flag;
    logic [5:0] limit;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic [7:0] command;
    logic [5:0] length;
    status_t    status;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first, poly 0x1021.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    begin
      x = crc[15:8] ^ b;
      x = x ^ (x >> 4);
      crc16_step = {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
                   ^ {8'h00, x};
    end
  endfunction

endpackage

`default_nettype wire

/* sv/ffrc_cfg.sv */
// Configuration registers of the framed receiver.
// Depends on ffrc_pkg for register indexes and the cfg_t struct.
`default_nettype none

module ffrc_cfg import ffrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output cfg_t            cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_flag <= START_FLAG_RST;
      cfg_r.end_flag   <= END_FLAG_RST;
      cfg_r.limit      <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_FLAG: cfg_r.start_flag <= cfg_wdata;
        REG_END_FLAG:   cfg_r.end_flag   <= cfg_wdata;
        REG_LIMIT:      cfg_r.limit      <= cfg_wdata[5:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/ffrc_parser.sv */
// Frame parser: phase machine, length clamp, payload count and running CRC.
// Depends on ffrc_pkg for cfg_t, result_t and crc16_step.
`default_nettype none

module ffrc_parser import ffrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       byte_take,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output result_t         res
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_CMD, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CRC_LO, PH_CRC_HI, PH_END
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [7:0]  cmd_r,     cmd_nxt;
  logic [7:0]  len_lo_r,  len_lo_nxt;
  logic [5:0]  target_r,  target_nxt;
  logic [5:0]  count_r,   count_nxt;
  logic [15:0] crc_r,     crc_nxt;
  logic [15:0] rx_crc_r,  rx_crc_nxt;

  logic [5:0]  lim;
  logic [15:0] req;

  always_comb begin
    lim = (cfg.limit > LIMIT_CAP) ? LIMIT_CAP : cfg.limit;
    req = {rx_byte, len_lo_r};

    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_lo_nxt = len_lo_r;
    target_nxt = target_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    rx_crc_nxt = rx_crc_r;
    res_valid  = 1'b0;
    res        = '0;

    if (byte_take) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == cfg.start_flag) phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_nxt = rx_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          target_nxt = (req > {10'd0, lim}) ? lim : req[5:0];
          count_nxt  = '0;
          crc_nxt    = CRC_INIT;
          phase_nxt  = (target_nxt == '0) ? PH_CRC_LO : PH_DATA;
        end
        PH_DATA: begin
          res_valid      = 1'b1;
          res.kind       = KIND_DATA;
          res.data_byte  = rx_byte;
          res.byte_index = count_r[4:0];
          crc_nxt        = crc16_step(crc_r, rx_byte);
          count_nxt      = count_r + 6'd1;
          if (count_nxt >= target_r) phase_nxt = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc_nxt = {8'h00, rx_byte};
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          rx_crc_nxt = {rx_byte, rx_crc_r[7:0]};
          phase_nxt  = PH_END;
        end
        PH_END: begin
          res_valid   = 1'b1;
          res.kind    = KIND_FRAME;
          res.command = cmd_r;
          res.length  = target_r;
          // bad end flag wins over CRC mismatch
          if (rx_byte != cfg.end_flag)  res.status = STAT_END_BAD;
          else if (rx_crc_r != crc_r)   res.status = STAT_CRC_BAD;
          else                          res.status = STAT_OK;
          phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cmd_r    <= '0;
      len_lo_r <= '0;
      target_r <= '0;
      count_r  <= '0;
      crc_r    <= CRC_INIT;
      rx_crc_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      len_lo_r <= len_lo_nxt;
      target_r <= target_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      rx_crc_r <= rx_crc_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/ffrc_outbuf.sv */
// Two-place output buffer (main register plus skid) for result words.
// Depends on ffrc_pkg for result_t.
`default_nettype none

module ffrc_outbuf import ffrc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_word,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_word
);

  logic    main_vld_r;
  logic    skid_vld_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop = main_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // full: no push can arrive; drain skid into main on pop
      if (pop) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!main_vld_r || pop) begin
      main_vld_r <= push;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) main_r <= skid_r;
    end else if (!main_vld_r || pop) begin
      if (push) main_r <= push_word;
    end else if (push) begin
      skid_r <= push_word;
    end
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_word  = main_r;

endmodule

`default_nettype wire

/* sv/flag_frame_receiver_crc16_core.sv */
// Top level of the flag-framed byte receiver with CRC-16/CCITT-FALSE check.
// Instantiates ffrc_cfg, ffrc_parser and ffrc_outbuf; uses ffrc_pkg.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_stall, in_rx_byte          | byte in
//   result   | out_valid, out_stall, out_* fields      | word out
//   config   | cfg_we, cfg_index, cfg_wdata            | write only
//
// One byte is taken per cycle while in_stall is low; phase, count and CRC update
// finish in the accepting cycle, and result words are registered into the buffer.
// in_stall rises only when both places of the output buffer hold words.
// Reset (synchronous, rst_n low) returns the parser to hunting for the start flag,
// loads the default flags and limit, and empties the output buffer.
`default_nettype none

module flag_frame_receiver_crc16_core import ffrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,

  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,

  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_result_kind,
  output logic [7:0]      out_data_byte,
  output logic [4:0]      out_byte_index,
  output logic [7:0]      out_frame_command,
  output logic [5:0]      out_frame_length,
  output logic [1:0]      out_frame_status
);

  cfg_t    cfg;
  logic    byte_take;
  logic    res_valid;
  result_t res;
  result_t out_word;
  logic    buf_full;

  assign in_stall  = buf_full;
  assign byte_take = in_valid && !buf_full;

  ffrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ffrc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_take (byte_take),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ffrc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_word (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_result_kind   = out_word.kind;
  assign out_data_byte     = out_word.data_byte;
  assign out_byte_index    = out_word.byte_index;
  assign out_frame_command = out_word.command;
  assign out_frame_length  = out_word.length;
  assign out_frame_status  = out_word.status;

endmodule

`default_nettype wire
